### rtl/binary_min_heap_queue_assert.svh
// Assertion macros for the heap queue.
// A check fires when its antecedent holds and its consequent does not.
`ifndef BINARY_MIN_HEAP_QUEUE_ASSERT_SVH
`define BINARY_MIN_HEAP_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define HMQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("heap queue check failed");

// Next-cycle implication.
`define HMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("heap queue check failed");

`else

`define HMQ_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define HMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/hmq_pkg.sv
`default_nettype none

package hmq_pkg;

	localparam int VALUE_W = 32;
	localparam int COUNT_W = 11;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_POP    = 1'b1;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic               kind;
		logic [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [VALUE_W-1:0] top_value;
		logic               is_empty;
		logic [COUNT_W-1:0] entry_count;
		logic [1:0]         status;
	} rsp_t;

	typedef struct packed {
		logic valid;
		rsp_t rsp;
	} done_t;

endpackage

`default_nettype wire

### rtl/hmq_stream_if.sv
`default_nettype none

interface hmq_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/hmq_ram.sv
`default_nettype none

module hmq_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
	output      logic [WIDTH-1:0]         rd_data_a,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output      logic [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_a <= mem_q[rd_addr_a];
		rd_data_b <= mem_q[rd_addr_b];
	end

endmodule

`default_nettype wire

### rtl/hmq_ctrl.sv
`default_nettype none
`include "binary_min_heap_queue_assert.svh"

module hmq_ctrl #(
	parameter int CAPACITY  = 1024,
	parameter int KEY_WIDTH = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	hmq_stream_if.sink         req,
	input  wire logic          out_free,
	output      hmq_pkg::done_t done
);
	import hmq_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = CW + 1;

	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_UP_ISSUE  = 3'd1;
	localparam logic [2:0] ST_UP_CMP    = 3'd2;
	localparam logic [2:0] ST_POP_ISSUE = 3'd3;
	localparam logic [2:0] ST_POP_LOAD  = 3'd4;
	localparam logic [2:0] ST_DN_ISSUE  = 3'd5;
	localparam logic [2:0] ST_DN_CMP    = 3'd6;
	localparam logic [2:0] ST_FIN       = 3'd7;

	logic [2:0]           st_q;
	logic [CW-1:0]        cnt_q;
	logic [AW-1:0]        idx_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [KEY_WIDTH-1:0] top_q;
	logic [1:0]           status_q;

	logic                 accept;
	logic                 is_full;
	logic [AW-1:0]        par_idx;
	logic [IW-1:0]        l_idx;
	logic [IW-1:0]        r_idx;
	logic                 has_r;
	logic                 dn_leaf;
	logic                 up_less;
	logic                 move;
	logic                 go_left;
	logic [KEY_WIDTH-1:0] child_val;
	logic [AW-1:0]        child_idx;

	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [KEY_WIDTH-1:0] wr_data;
	logic [AW-1:0]        rd_addr_a;
	logic [AW-1:0]        rd_addr_b;
	logic [KEY_WIDTH-1:0] rd_data_a;
	logic [KEY_WIDTH-1:0] rd_data_b;

	hmq_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (KEY_WIDTH)
	) u_ram (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr_a (rd_addr_a),
		.rd_data_a (rd_data_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_b (rd_data_b)
	);

	assign req.ready = (st_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign is_full   = (cnt_q == CW'(CAPACITY));

	assign par_idx = (idx_q - AW'(1)) >> 1;
	assign l_idx   = (IW'(idx_q) << 1) + IW'(1);
	assign r_idx   = l_idx + IW'(1);
	assign has_r   = r_idx < IW'(cnt_q);
	assign dn_leaf = l_idx >= IW'(cnt_q);
	assign up_less = key_q < rd_data_a;

	// Children arrive together on the two read ports; ties go right.
	assign move      = (key_q > rd_data_a) || (has_r && (key_q > rd_data_b));
	assign go_left   = !has_r || (rd_data_a < rd_data_b);
	assign child_val = go_left ? rd_data_a : rd_data_b;
	assign child_idx = go_left ? l_idx[AW-1:0] : r_idx[AW-1:0];

	// The moving key stays in key_q; each level writes either the key or the
	// entry that trades places with the hole.
	always_comb begin
		wr_en     = 1'b0;
		wr_addr   = idx_q;
		wr_data   = key_q;
		rd_addr_a = par_idx;
		rd_addr_b = r_idx[AW-1:0];
		case (st_q)
			ST_UP_ISSUE: begin
				wr_en = (idx_q == '0);
			end
			ST_UP_CMP: begin
				wr_en = 1'b1;
				if (up_less) begin
					wr_data = rd_data_a;
				end
			end
			ST_POP_ISSUE: begin
				rd_addr_a = cnt_q[AW-1:0];
			end
			ST_DN_ISSUE: begin
				rd_addr_a = l_idx[AW-1:0];
				wr_en     = dn_leaf;
			end
			ST_DN_CMP: begin
				wr_en = 1'b1;
				if (move) begin
					wr_data = child_val;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						if (req.payload.kind == KIND_INSERT) begin
							if (is_full) begin
								st_q <= ST_FIN;
							end else begin
								cnt_q <= cnt_q + CW'(1);
								st_q  <= ST_UP_ISSUE;
							end
						end else begin
							if (cnt_q == '0) begin
								st_q <= ST_FIN;
							end else begin
								cnt_q <= cnt_q - CW'(1);
								st_q  <= ST_POP_ISSUE;
							end
						end
					end
				end
				ST_UP_ISSUE:  st_q <= (idx_q == '0) ? ST_FIN : ST_UP_CMP;
				ST_UP_CMP:    st_q <= up_less ? ST_UP_ISSUE : ST_FIN;
				ST_POP_ISSUE: st_q <= (cnt_q == '0) ? ST_FIN : ST_POP_LOAD;
				ST_POP_LOAD:  st_q <= ST_DN_ISSUE;
				ST_DN_ISSUE:  st_q <= dn_leaf ? ST_FIN : ST_DN_CMP;
				ST_DN_CMP:    st_q <= move ? ST_DN_ISSUE : ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= KEY_WIDTH'(req.payload.value);
			idx_q <= cnt_q[AW-1:0];
			if (req.payload.kind == KIND_INSERT) begin
				status_q <= is_full ? STATUS_FULL : STATUS_OK;
			end else begin
				status_q <= (cnt_q == '0) ? STATUS_EMPTY : STATUS_OK;
			end
		end
		if (st_q == ST_UP_CMP && up_less) begin
			idx_q <= par_idx;
		end
		if (st_q == ST_POP_LOAD) begin
			key_q <= rd_data_a;
			idx_q <= '0;
		end
		if (st_q == ST_DN_CMP && move) begin
			idx_q <= child_idx;
		end
		// Shadow the root so the result needs no extra memory read.
		if (wr_en && wr_addr == '0) begin
			top_q <= wr_data;
		end
	end

	always_comb begin
		done.valid           = (st_q == ST_FIN);
		done.rsp.top_value   = (cnt_q != '0) ? VALUE_W'(top_q) : '0;
		done.rsp.is_empty    = (cnt_q == '0);
		done.rsp.entry_count = COUNT_W'(cnt_q);
		done.rsp.status      = status_q;
	end

	`HMQ_ASSERT_NOW(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CW'(CAPACITY))
	`HMQ_ASSERT_NEXT(a_full_flag, clk, arst_n,
		accept && req.payload.kind == KIND_INSERT && is_full,
		st_q == ST_FIN && status_q == STATUS_FULL && $stable(cnt_q))
	`HMQ_ASSERT_NEXT(a_empty_flag, clk, arst_n,
		accept && req.payload.kind == KIND_POP && cnt_q == '0,
		st_q == ST_FIN && status_q == STATUS_EMPTY && cnt_q == '0)
	`HMQ_ASSERT_NEXT(a_cnt_hold, clk, arst_n, st_q != ST_IDLE, $stable(cnt_q))
	`HMQ_ASSERT_NOW(a_hole_inside, clk, arst_n, st_q == ST_DN_CMP, CW'(idx_q) < cnt_q)

endmodule

`default_nettype wire

### rtl/binary_min_heap_queue.sv
// Binary min-heap priority queue, one request in flight at a time.
// Insert: the new key sifts up from the new last slot, L = levels climbed (at most log2(CAPACITY)).
// Pop: the last entry sifts down from the root, L = levels descended; a rejected request goes straight to the result.
// Each level costs a read and a compare/write on the registered-read heap memory.
// The result register lets the next request enter while a result waits.
// Reset clears the entry count and all control; heap memory contents are not cleared.
`default_nettype none

module binary_min_heap_queue #(
	parameter int CAPACITY  = 1024,
	parameter int KEY_WIDTH = 32
) (
	input wire logic   clk,
	input wire logic   arst_n,
	hmq_stream_if.sink   req,
	hmq_stream_if.source rsp
);
	import hmq_pkg::*;

	done_t done;
	logic  out_free;
	logic  rsp_valid_q;
	rsp_t  rsp_q;

	assign out_free = !rsp_valid_q || rsp.ready;

	hmq_ctrl #(
		.CAPACITY  (CAPACITY),
		.KEY_WIDTH (KEY_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.out_free (out_free),
		.done     (done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done.valid && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done.valid && out_free) begin
			rsp_q <= done.rsp;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

endmodule

`default_nettype wire
